/* rtl/pir_pkg.sv */
// ----------------------------------------------------------------------------
// pir_pkg
// Types and constants shared by the PCI INTx interrupt router files.
// ----------------------------------------------------------------------------
`default_nettype none

package pir_pkg;

	// Field widths of one event and one result.
	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 3;
	localparam int PIN_W    = 3;
	localparam int LEVELS_W = 16;
	localparam int LINE_W   = 3;

	// Routing resources.
	localparam int PINS_PER_SLOT = 4;
	localparam int LINES         = 4;
	localparam int IRQ_W         = 5;
	localparam int COUNT_W       = 6;
	localparam int ENTRY_W       = 3;
	localparam int SWZ_W         = 48;
	localparam int SWZ_ENTRIES   = SWZ_W / ENTRY_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Event modes.
	localparam logic [MODE_W-1:0] MODE_RAISE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SWZ_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWZ_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_C  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_D  = 3'd5;

	// Reset value of a route IRQ register: the line drives nothing.
	localparam logic [IRQ_W-1:0] IRQ_OFF = 5'd16;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [PIN_W-1:0]  int_pin;
	} event_t;

	typedef struct packed {
		logic [LEVELS_W-1:0] irq_levels;
		logic                changed;
		logic [LINE_W-1:0]   routed_line;
	} result_t;

	typedef struct packed {
		logic [SWZ_W-1:0]              swz_lo;
		logic [SWZ_W-1:0]              swz_hi;
		logic [LINES-1:0][IRQ_W-1:0]   line_irq;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/pir_event_if.sv */
// ----------------------------------------------------------------------------
// pir_event_if
// Valid/ready channel that carries one interrupt event.
// ----------------------------------------------------------------------------
`default_nettype none

interface pir_event_if
	import pir_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SLOT_W-1:0] slot;
	logic [PIN_W-1:0]  int_pin;

	modport source(output valid, output mode, output slot, output int_pin, input ready);
	modport sink(input valid, input mode, input slot, input int_pin, output ready);
endinterface

`default_nettype wire

/* rtl/pir_result_if.sv */
// ----------------------------------------------------------------------------
// pir_result_if
// Valid/ready channel that carries one router result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pir_result_if
	import pir_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [LEVELS_W-1:0] irq_levels;
	logic                changed;
	logic [LINE_W-1:0]   routed_line;

	modport source(output valid, output irq_levels, output changed, output routed_line,
		input ready);
	modport sink(input valid, input irq_levels, input changed, input routed_line,
		output ready);
endinterface

`default_nettype wire

/* rtl/pci_intx_interrupt_router_top.sv */
// ----------------------------------------------------------------------------
// pci_intx_interrupt_router_top
// PCI INTx router: slot pins pass through a per-slot swizzle onto four
// counted lines, which drive configurable interrupt-controller IRQs.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   evt       in         valid / ready        mode, slot, int_pin
//   res       out        valid / ready        irq_levels, changed, routed_line
//   cfg       in         cfg_wr_en (no wait)  cfg_index, cfg_wdata
//
// Every event passes from acceptance through the input register, then
// through the state update into the result register.
// A new event is accepted in every cycle while results are taken; the state
// update at the input register sets the throughput of one event per cycle.
// The evt ready signal drops only while the result register holds a result
// that has not been taken and the input register is full.
// Reset clears the assertion bits and counters at once, sets the swizzle
// registers to zero and every route IRQ to disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_intx_interrupt_router_top
	import pir_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_wdata,
	pir_event_if.sink              evt,
	pir_result_if.source           res
);

	// Configuration registers. The user must write them only while the block is idle;
	// the block does not enforce this and has no interlock with events in flight.
	logic [SWZ_W-1:0]              swz_lo_q;
	logic [SWZ_W-1:0]              swz_hi_q;
	logic [LINES-1:0][IRQ_W-1:0]   line_irq_q;
	cfg_t                          cfg;

	// Input register and result register.
	event_t   evt_s1;
	logic     vld_s1;
	result_t  res_q;
	logic     res_vld_q;
	result_t  core_res;
	logic     adv;
	logic     evt_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swz_lo_q   <= '0;
			swz_hi_q   <= '0;
			line_irq_q <= {LINES{IRQ_OFF}};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SWZ_LO: swz_lo_q      <= cfg_wdata[SWZ_W-1:0];
				REG_SWZ_HI: swz_hi_q      <= cfg_wdata[SWZ_W-1:0];
				REG_IRQ_A:  line_irq_q[0] <= cfg_wdata[IRQ_W-1:0];
				REG_IRQ_B:  line_irq_q[1] <= cfg_wdata[IRQ_W-1:0];
				REG_IRQ_C:  line_irq_q[2] <= cfg_wdata[IRQ_W-1:0];
				REG_IRQ_D:  line_irq_q[3] <= cfg_wdata[IRQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.swz_lo   = swz_lo_q;
	assign cfg.swz_hi   = swz_hi_q;
	assign cfg.line_irq = line_irq_q;

	// The event in the input register moves on whenever the result register
	// is empty or its result is being taken in the same cycle. The state is
	// updated at that same edge, so the next event sees it right away.
	assign adv       = vld_s1 && (!res_vld_q || res.ready);
	assign evt.ready = !vld_s1 || adv;
	assign evt_acc   = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			evt_s1.mode    <= evt.mode;
			evt_s1.slot    <= evt.slot;
			evt_s1.int_pin <= evt.int_pin;
		end
	end

	pir_state #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (adv),
		.evt    (evt_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= core_res;
		end
	end

	assign res.valid       = res_vld_q;
	assign res.irq_levels  = res_q.irq_levels;
	assign res.changed     = res_q.changed;
	assign res.routed_line = res_q.routed_line;

`ifndef ASSERT_OFF
	// A result that names a routed line always reports a state change.
	a_line_implies_change: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.routed_line == '0 || res.changed))
		else $error("routed line reported without a state change");

	// The routed line is never beyond line D.
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.routed_line <= 3'd4))
		else $error("routed line out of range");

	// A clear-all leaves every line idle, so no IRQ is driven and no line named.
	a_clear_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && evt_s1.mode == MODE_CLEAR) |=>
		(res.irq_levels == '0 && res.routed_line == '0))
		else $error("clear-all left an IRQ level or routed line set");

	// An event held in the input register is not overwritten while it waits.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(evt_s1)))
		else $error("waiting event in the input register was lost or changed");
`endif

endmodule

`default_nettype wire

/* rtl/pir_state.sv */
// ----------------------------------------------------------------------------
// pir_state
// Source assertion bits, per-line counters and the IRQ level decode.
// ----------------------------------------------------------------------------
`default_nettype none

module pir_state
	import pir_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     upd_en,
	input  event_t  evt,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int SRC_W = SLOT_COUNT * PINS_PER_SLOT;

	logic [SRC_W-1:0]                src_q;
	logic [SRC_W-1:0]                src_d;
	logic [LINES-1:0][COUNT_W-1:0]   cnt_q;
	logic [LINES-1:0][COUNT_W-1:0]   cnt_d;

	logic [PIN_W-1:0]         pin_dec;
	logic [1:0]               pin_idx;
	logic [SLOT_W+1:0]        src_idx;
	logic [SRC_W-1:0]         src_hit;
	logic                     src_set;
	logic                     slot_ok;
	logic                     pin_ok;
	logic [SWZ_W-1:0]         swz_sel;
	logic [ENTRY_W-1:0]       swz_ent [SWZ_ENTRIES];
	logic [ENTRY_W-1:0]       ent;
	logic [LINE_W-1:0]        route;
	logic [1:0]               line_idx;
	logic                     changed;
	logic [LINE_W-1:0]        line;
	logic [LEVELS_W-1:0]      levels;

	always_comb begin
		pin_dec = evt.int_pin - 3'd1;
		pin_idx = pin_dec[1:0];
		src_idx = {evt.slot, pin_idx};
		for (int i = 0; i < SRC_W; i++) begin
			src_hit[i] = (src_idx == (SLOT_W+2)'(i));
		end
		src_set = |(src_q & src_hit);
		slot_ok = ({1'b0, evt.slot} < (SLOT_W+1)'(SLOT_COUNT));
		pin_ok  = evt.int_pin inside {[3'd1:3'd4]};

		// Swizzle lookup: an entry outside 1..4 falls back to the pin itself.
		swz_sel = evt.slot[2] ? cfg.swz_hi : cfg.swz_lo;
		for (int k = 0; k < SWZ_ENTRIES; k++) begin
			swz_ent[k] = swz_sel[ENTRY_W*k +: ENTRY_W];
		end
		ent = swz_ent[{evt.slot[1:0], pin_idx}];
		if (ent inside {[3'd1:3'd4]}) begin
			route = ent;
		end else begin
			route = evt.int_pin;
		end
		line_idx = 2'(route - 3'd1);

		src_d   = src_q;
		cnt_d   = cnt_q;
		changed = 1'b0;
		line    = '0;
		case (evt.mode)
			MODE_CLEAR: begin
				changed = (|src_q) || (|cnt_q);
				src_d   = '0;
				cnt_d   = '0;
			end
			MODE_RAISE: begin
				if (slot_ok && pin_ok && !src_set) begin
					src_d           = src_q | src_hit;
					cnt_d[line_idx] = cnt_q[line_idx] + COUNT_W'(1);
					changed         = 1'b1;
					line            = route;
				end
			end
			MODE_LOWER: begin
				if (slot_ok && pin_ok && src_set) begin
					src_d = src_q & ~src_hit;
					if (cnt_q[line_idx] != '0) begin
						cnt_d[line_idx] = cnt_q[line_idx] - COUNT_W'(1);
					end
					changed = 1'b1;
					line    = route;
				end
			end
			default: begin
				changed = 1'b0;
			end
		endcase

		// Lines that share an IRQ are ORed together.
		levels = '0;
		for (int n = 0; n < LINES; n++) begin
			if (!cfg.line_irq[n][IRQ_W-1] && cnt_d[n] != '0) begin
				levels[cfg.line_irq[n][IRQ_W-2:0]] = 1'b1;
			end
		end

		result.irq_levels  = levels;
		result.changed     = changed;
		result.routed_line = line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			cnt_q <= '0;
		end else if (upd_en) begin
			src_q <= src_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

`default_nettype wire

/* tb/pir_levels_checker.sv */
// ----------------------------------------------------------------------------
// pir_levels_checker
// Watches the event, result and register ports of the interrupt router,
// computes the IRQ level vector that each accepted event must produce, and
// compares every result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module pir_levels_checker
	import pir_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_wdata,
	pir_event_if                 evt,
	pir_result_if                res,
	output int                   fail_count,
	output int                   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SOURCES        = SLOT_COUNT * PINS_PER_SLOT;
	localparam int SLOTS_PER_WORD = SWZ_ENTRIES / PINS_PER_SLOT;
	localparam int REPORT_LIMIT   = 10;

	// Shadow of the router: configuration and routing state.
	logic [SWZ_W-1:0]   swz_lo;
	logic [SWZ_W-1:0]   swz_hi;
	logic [IRQ_W-1:0]   line_irq [LINES];
	logic [SOURCES-1:0] src_up;
	logic [COUNT_W-1:0] line_cnt [LINES];

	result_t levels_due[$];
	int      errors;

	function automatic logic [LINE_W-1:0] swizzled_line(input logic [SLOT_W-1:0] s,
		input logic [PIN_W-1:0] p);
		logic [SWZ_W-1:0]   word;
		logic [ENTRY_W-1:0] entry;
		int                 shift;
		word  = (int'(s) < SLOTS_PER_WORD) ? swz_lo : swz_hi;
		shift = (int'(s) % SLOTS_PER_WORD) * PINS_PER_SLOT * ENTRY_W + (int'(p) - 1) * ENTRY_W;
		entry = word[shift +: ENTRY_W];
		if (entry >= 1 && int'(entry) <= LINES)
			return LINE_W'(entry);
		return LINE_W'(p);
	endfunction

	function automatic logic [LEVELS_W-1:0] irq_vector();
		logic [LEVELS_W-1:0] v;
		v = '0;
		for (int i = 0; i < LINES; i++) begin
			if (line_irq[i] < IRQ_OFF && line_cnt[i] != '0)
				v[line_irq[i][3:0]] = 1'b1;
		end
		return v;
	endfunction

	task automatic route_event(input event_t e, output result_t r);
		logic [LINE_W-1:0] ln;
		logic              chg;
		int                idx;
		ln  = '0;
		chg = 1'b0;
		if (e.mode == MODE_CLEAR) begin
			chg = (src_up != '0);
			for (int i = 0; i < LINES; i++) begin
				if (line_cnt[i] != '0)
					chg = 1'b1;
				line_cnt[i] = '0;
			end
			src_up = '0;
		end else if ((e.mode == MODE_RAISE || e.mode == MODE_LOWER) &&
			int'(e.slot) < SLOT_COUNT && e.int_pin >= 1 && int'(e.int_pin) <= PINS_PER_SLOT) begin
			idx = int'(e.slot) * PINS_PER_SLOT + int'(e.int_pin) - 1;
			if (e.mode == MODE_RAISE && !src_up[idx]) begin
				ln                = swizzled_line(e.slot, e.int_pin);
				src_up[idx]       = 1'b1;
				line_cnt[ln - 1]  = line_cnt[ln - 1] + 1'b1;
				chg               = 1'b1;
			end else if (e.mode == MODE_LOWER && src_up[idx]) begin
				// The lower follows the current swizzle, which may differ from the raise.
				ln          = swizzled_line(e.slot, e.int_pin);
				src_up[idx] = 1'b0;
				if (line_cnt[ln - 1] != '0)
					line_cnt[ln - 1] = line_cnt[ln - 1] - 1'b1;
				chg = 1'b1;
			end
		end
		r.irq_levels  = irq_vector();
		r.changed     = chg;
		r.routed_line = ln;
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_t  ev;
		result_t got;
		result_t want;
		if (!arst_n) begin
			swz_lo = '0;
			swz_hi = '0;
			for (int i = 0; i < LINES; i++) begin
				line_irq[i] = IRQ_OFF;
				line_cnt[i] = '0;
			end
			src_up = '0;
			levels_due.delete();
			errors = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got.irq_levels  = res.irq_levels;
				got.changed     = res.changed;
				got.routed_line = res.routed_line;
				if (levels_due.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("%0t: result with no event outstanding: levels=%h changed=%0d line=%0d",
							$realtime, got.irq_levels, got.changed, got.routed_line);
					errors++;
				end else begin
					want = levels_due.pop_front();
					if (got.irq_levels !== want.irq_levels || got.changed !== want.changed ||
						got.routed_line !== want.routed_line) begin
						if (errors < REPORT_LIMIT)
							$display("%0t: mismatch: expected levels=%h changed=%0d line=%0d, got levels=%h changed=%0d line=%0d",
								$realtime, want.irq_levels, want.changed, want.routed_line,
								got.irq_levels, got.changed, got.routed_line);
						errors++;
					end
				end
			end
			if (evt.valid && evt.ready) begin
				ev.mode    = evt.mode;
				ev.slot    = evt.slot;
				ev.int_pin = evt.int_pin;
				route_event(ev, want);
				levels_due.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SWZ_LO: swz_lo      = cfg_wdata[SWZ_W-1:0];
					REG_SWZ_HI: swz_hi      = cfg_wdata[SWZ_W-1:0];
					REG_IRQ_A:  line_irq[0] = cfg_wdata[IRQ_W-1:0];
					REG_IRQ_B:  line_irq[1] = cfg_wdata[IRQ_W-1:0];
					REG_IRQ_C:  line_irq[2] = cfg_wdata[IRQ_W-1:0];
					REG_IRQ_D:  line_irq[3] = cfg_wdata[IRQ_W-1:0];
					default: begin
					end
				endcase
			end
			fail_count    <= errors;
			pending_count <= levels_due.size();
		end
	end

endmodule

/* tb/pci_intx_interrupt_router_top_tb.sv */
// ----------------------------------------------------------------------------
// pci_intx_interrupt_router_top_tb
// Drives interrupt events and register writes into the INTx router and lets
// a checker beside it predict and compare every result transfer.
// ----------------------------------------------------------------------------

module pci_intx_interrupt_router_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pir_pkg::*;

	localparam int SLOTS        = 8;
	localparam int SOURCES      = SLOTS * PINS_PER_SLOT;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int EVENT_TARGET = 1150;
	localparam int PHASES       = 8;
	localparam int LONG_HOLD    = 100;
	// Edges waited after the last result is taken, before any register write.
	localparam int SETTLE       = 4;
	localparam int TAIL         = 8;

	// Codes the router does not define: an unused mode and two spare indexes.
	localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pir_event_if  evt_if();
	pir_result_if res_if();

	int fail_count;
	int pending_count;

	// Flags for the event driver; the first two also reach the result sink. The driver sets
	// these with blocking assignments; the sink only reads them, except that
	// it acknowledges a long hold by clearing its request.
	bit quiet;
	bit long_hold_req;
	int tx_gap_pct;

	// Which sources the driver believes are up, so that most lowers hit.
	logic [SOURCES-1:0] up_mask;

	int cycles;

	pci_intx_interrupt_router_top #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_if),
		.res       (res_if)
	);

	pir_levels_checker #(
		.SLOT_COUNT(SLOTS)
	) levels_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.evt           (evt_if),
		.res           (res_if),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// The run is cut off if it takes far longer than the slowest correct run.
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Result sink. Ready drops in bursts, at a rate that changes from stretch
	// to stretch, and some stretches have no stalls at all. On request it holds
	// off for a long, counted stretch so that the router fills up and pushes
	// back on the event side. Near the end of the run it never stalls.
	initial begin : result_sink
		int stall_left;
		int rx_pct;
		int span;
		res_if.ready <= 1'b0;
		stall_left = 0;
		rx_pct     = 0;
		span       = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
					0:       rx_pct = 0;
					1:       rx_pct = 8;
					default: rx_pct = 30;
				endcase
			end
			span--;
			if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD - 1;
				res_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
				stall_left = $urandom_range(1, 7) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Offer one event and wait for its transfer. A random gap may come first;
	// otherwise valid stays high and only the payload changes, so back-to-back
	// transfers happen. The driver's view of the raised sources follows along.
	task automatic send_event(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
		input logic [PIN_W-1:0] p);
		int gap;
		int idx;
		if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 7);
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid   <= 1'b1;
		evt_if.mode    <= m;
		evt_if.slot    <= s;
		evt_if.int_pin <= p;
		do
			@(posedge clk);
		while (!evt_if.ready);
		if (m == MODE_CLEAR) begin
			up_mask = '0;
		end else if (int'(s) < SLOTS && p >= 1 && int'(p) <= PINS_PER_SLOT) begin
			idx = int'(s) * PINS_PER_SLOT + int'(p) - 1;
			if (m == MODE_RAISE)
				up_mask[idx] = 1'b1;
			else if (m == MODE_LOWER)
				up_mask[idx] = 1'b0;
		end
	endtask

	// Stop offering events and wait until every predicted result has been
	// taken, then let the router settle so that a register write finds it idle.
	// The checker's count is registered, so the loop waits for an edge before it looks.
	task automatic drain_results();
		evt_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write per cycle; the write enable stays high across the
	// whole burst and drops after it.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Writes every register. With spare set, a write to an undefined index
	// follows, which the router must ignore.
	task automatic program_config(input cfg_t c, input bit spare);
		put_reg(REG_SWZ_LO, CFG_DATA_W'(c.swz_lo));
		put_reg(REG_SWZ_HI, CFG_DATA_W'(c.swz_hi));
		put_reg(REG_IRQ_A, CFG_DATA_W'(c.line_irq[0]));
		put_reg(REG_IRQ_B, CFG_DATA_W'(c.line_irq[1]));
		put_reg(REG_IRQ_C, CFG_DATA_W'(c.line_irq[2]));
		put_reg(REG_IRQ_D, CFG_DATA_W'(c.line_irq[3]));
		if (spare)
			put_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
				CFG_DATA_W'({$urandom, $urandom}));
		cfg_wr_en <= 1'b0;
	endtask

	// A swizzle word. With routed_only every entry names a line; otherwise
	// every entry is uniform over its three bits, so fallbacks occur as well.
	function automatic logic [SWZ_W-1:0] rand_swizzle(input bit routed_only);
		logic [SWZ_W-1:0] w;
		w = '0;
		for (int i = 0; i < SWZ_ENTRIES; i++)
			w[i*ENTRY_W +: ENTRY_W] = routed_only ? ENTRY_W'($urandom_range(1, LINES))
				: ENTRY_W'($urandom_range(0, 7));
		return w;
	endfunction

	// Register settings per phase: the first two phases take the extremes, the
	// later ones are random, some with lines disabled or sharing an IRQ.
	function automatic cfg_t phase_config(input int ph);
		cfg_t c;
		logic [IRQ_W-1:0] shared;
		case (ph)
			0: begin
				c.swz_lo   = '0;
				c.swz_hi   = '0;
				c.line_irq = {5'd3, 5'd2, 5'd1, 5'd0};
			end
			1: begin
				// Entry seven everywhere: every pin falls back to itself, and all
				// four lines share the top IRQ.
				c.swz_lo   = '1;
				c.swz_hi   = '1;
				c.line_irq = {5'd15, 5'd15, 5'd15, 5'd15};
			end
			2: begin
				c.swz_lo = rand_swizzle(1'b1);
				c.swz_hi = rand_swizzle(1'b1);
				for (int i = 0; i < LINES; i++)
					c.line_irq[i] = IRQ_W'($urandom_range(0, 15));
			end
			3: begin
				c.swz_lo = rand_swizzle(1'b0);
				c.swz_hi = rand_swizzle(1'b0);
				for (int i = 0; i < LINES; i++)
					c.line_irq[i] = IRQ_W'($urandom_range(0, 31));
			end
			4: begin
				shared     = IRQ_W'($urandom_range(0, 15));
				c.swz_lo   = rand_swizzle(1'b0);
				c.swz_hi   = rand_swizzle(1'b0);
				c.line_irq = {IRQ_OFF, 5'd31, shared, shared};
			end
			default: begin
				c.swz_lo = rand_swizzle(1'($urandom_range(0, 1)));
				c.swz_hi = rand_swizzle(1'($urandom_range(0, 1)));
				for (int i = 0; i < LINES; i++)
					c.line_irq[i] = IRQ_W'($urandom_range(0, 17));
			end
		endcase
		return c;
	endfunction

	// One random event. Most are raises and lowers of real sources, with
	// lowers aimed mostly at sources that are up; a few clear everything, and
	// the rest is noise the router must ignore: pins outside INTA..INTD and
	// the unused mode. Noise does not count toward the item total.
	task automatic random_item(output bit counted);
		int                r;
		int                idx;
		logic [MODE_W-1:0] m;
		logic [PIN_W-1:0]  p;
		r       = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < 50) begin
			send_event(MODE_RAISE, SLOT_W'($urandom_range(0, SLOTS - 1)),
				PIN_W'($urandom_range(1, PINS_PER_SLOT)));
		end else if (r < 82) begin
			if (up_mask != '0 && $urandom_range(0, 3) != 0) begin
				do
					idx = $urandom_range(0, SOURCES - 1);
				while (!up_mask[idx]);
				send_event(MODE_LOWER, SLOT_W'(idx / PINS_PER_SLOT),
					PIN_W'(idx % PINS_PER_SLOT + 1));
			end else begin
				send_event(MODE_LOWER, SLOT_W'($urandom_range(0, SLOTS - 1)),
					PIN_W'($urandom_range(1, PINS_PER_SLOT)));
			end
		end else if (r < 86) begin
			send_event(MODE_CLEAR, SLOT_W'($urandom_range(0, SLOTS - 1)),
				PIN_W'($urandom_range(0, 7)));
		end else begin
			counted = 1'b0;
			if ($urandom_range(0, 2) == 0) begin
				send_event(MODE_SPARE, SLOT_W'($urandom_range(0, SLOTS - 1)),
					PIN_W'($urandom_range(0, 7)));
			end else begin
				case ($urandom_range(0, 3))
					0:       p = 3'd0;
					1:       p = 3'd5;
					2:       p = 3'd6;
					default: p = 3'd7;
				endcase
				m = $urandom_range(0, 1) ? MODE_LOWER : MODE_RAISE;
				send_event(m, SLOT_W'($urandom_range(0, SLOTS - 1)), p);
			end
		end
	endtask

	initial begin : stimulus
		cfg_t setup;
		int   ph;
		int   n;
		int   per_phase;
		bit   counted;

		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_index      <= '0;
		cfg_wdata      <= '0;
		evt_if.valid   <= 1'b0;
		evt_if.mode    <= '0;
		evt_if.slot    <= '0;
		evt_if.int_pin <= '0;
		quiet          = 1'b0;
		long_hold_req  = 1'b0;
		tx_gap_pct     = 10;
		up_mask        = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset every line is disabled: the source is counted, yet no
		// IRQ level rises.
		send_event(MODE_RAISE, 3'd0, 3'd1);
		send_event(MODE_LOWER, 3'd0, 3'd1);
		drain_results();

		// Slot 0 is identity, slot 1 reverses its pins, slot 2 has entry seven
		// on every pin so each falls back to itself, and slot 3 mixes fallback
		// entries with a real one. Lines B and C share IRQ 15; line D is off.
		setup.swz_lo   = {12'h235, 12'hFFF, 12'h29C, 12'h000};
		setup.swz_hi   = '0;
		setup.line_irq = {IRQ_OFF, 5'd15, 5'd15, 5'd0};
		program_config(setup, 1'b0);

		send_event(MODE_RAISE, 3'd0, 3'd1);   // line A drives IRQ 0
		send_event(MODE_RAISE, 3'd0, 3'd1);   // repeated raise is ignored
		send_event(MODE_LOWER, 3'd7, 3'd4);   // lower of a source that is not up
		send_event(MODE_RAISE, 3'd5, 3'd0);   // pin below INTA
		send_event(MODE_RAISE, 3'd6, 3'd7);   // pin above INTD
		send_event(MODE_SPARE, 3'd0, 3'd1);   // unused mode
		send_event(MODE_RAISE, 3'd1, 3'd1);   // swizzled onto the disabled line D
		send_event(MODE_RAISE, 3'd2, 3'd3);   // fallback onto line C, IRQ 15
		send_event(MODE_RAISE, 3'd7, 3'd2);   // line B shares IRQ 15
		send_event(MODE_LOWER, 3'd2, 3'd3);   // IRQ 15 stays up through line B
		send_event(MODE_RAISE, 3'd3, 3'd1);   // fallback entry, line A
		send_event(MODE_RAISE, 3'd3, 3'd4);   // entry one, line A again
		send_event(MODE_LOWER, 3'd0, 3'd1);
		send_event(MODE_LOWER, 3'd1, 3'd1);
		send_event(MODE_CLEAR, 3'd0, 3'd0);   // clears something
		send_event(MODE_CLEAR, 3'd7, 3'd7);   // clears nothing
		send_event(MODE_RAISE, 3'd4, 3'd1);   // upper word, identity onto A
		send_event(MODE_RAISE, 3'd4, 3'd4);   // onto D
		drain_results();

		// Move slot 4 INTA onto line B while it is up, so its lower hits a line
		// with a zero count. The IRQ numbers take their extremes: line A is
		// disabled through the top value, B uses IRQ 0, C the first disabled
		// value, D a middle one.
		setup.swz_hi   = 48'h2;
		setup.line_irq = {5'd7, IRQ_OFF, 5'd0, 5'd31};
		program_config(setup, 1'b0);

		send_event(MODE_LOWER, 3'd4, 3'd1);
		send_event(MODE_LOWER, 3'd4, 3'd4);
		send_event(MODE_CLEAR, 3'd0, 3'd0);

		// Random phases. Sources stay up across register changes, so lowers
		// after a swizzle change keep happening. Each phase starts only once
		// every result of the last one has come back. The last phase runs
		// without any idling on either side.
		per_phase = EVENT_TARGET / PHASES;
		for (ph = 0; ph < PHASES; ph++) begin
			drain_results();
			program_config(phase_config(ph), ph % 2 == 1);
			quiet = (ph == PHASES - 1);
			if (quiet)
				tx_gap_pct = 0;
			if (ph == 2) begin
				// The sink holds off while events keep coming back to back.
				long_hold_req = 1'b1;
				tx_gap_pct    = 0;
			end
			n = 0;
			while (n < per_phase) begin
				if (!quiet && n % 40 == 0 && !(ph == 2 && n < 80)) begin
					case ($urandom_range(0, 2))
						0:       tx_gap_pct = 0;
						1:       tx_gap_pct = 10;
						default: tx_gap_pct = 35;
					endcase
				end
				random_item(counted);
				if (counted)
					n++;
			end
		end

		drain_results();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
